// File: hw/rtl/pal_pkg.sv
// ---------------------------------------------------------------------------
// pal_pkg
// Shared types for the positional array list: request kinds and the command
// and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package pal_pkg;

   typedef enum logic [1:0] {
      KIND_GET    = 2'd0,
      KIND_LOCATE = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef struct packed {
      logic load;
      logic idx_init;
      logic idx_step;
      logic rd;
      logic wr_shift;
      logic wr_value;
      logic set_ok;
      logic take_rval;
      logic take_found;
      logic count_inc;
      logic count_dec;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pos_ok;
      logic     more;
      logic     match;
   } status_type;

endpackage

// File: hw/rtl/pal_ctrl.sv
// ---------------------------------------------------------------------------
// pal_ctrl
// Sequencer for the list: dispatches on the request kind, steps the scan and
// shift loops one entry at a time and raises the result strobe.
// ---------------------------------------------------------------------------
module pal_ctrl
   import pal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type st,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GET,
      ST_LOC_RD,
      ST_LOC_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.idx_init = 1'b1;
            unique case (st.kind) inside
               KIND_GET: begin
                  if (st.pos_ok) begin
                     cmd.rd   = 1'b1;
                     state_in = ST_GET;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               KIND_LOCATE: begin
                  cmd.set_ok = 1'b1;
                  state_in   = ST_LOC_RD;
               end
               KIND_INSERT, KIND_DELETE: begin
                  state_in = st.pos_ok ? ST_SHIFT_RD : ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_GET: begin
            cmd.take_rval = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_LOC_RD: begin
            if (st.more) begin
               cmd.rd   = 1'b1;
               state_in = ST_LOC_CMP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOC_CMP: begin
            if (st.match) begin
               cmd.take_found = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = ST_LOC_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (st.more) begin
               cmd.rd   = 1'b1;
               state_in = ST_SHIFT_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_step = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            cmd.set_ok = 1'b1;
            if (st.kind == KIND_INSERT) begin
               cmd.wr_value  = 1'b1;
               cmd.count_inc = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy_in   = (state_in != ST_IDLE);
   assign strobe_in = (state_ff != ST_IDLE) && (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without preceding work");

   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy)
      else $error("busy while idle");

endmodule

// File: hw/rtl/pal_datapath.sv
// ---------------------------------------------------------------------------
// pal_datapath
// Entry memory, entry count, loop index, request and result registers.
// Evaluates position checks and loop conditions for the controller.
// ---------------------------------------------------------------------------
module pal_datapath
   import pal_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         st,
   input  logic        [1:0]  req_kind,
   input  logic        [7:0]  req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_ok,
   output logic        [7:0]  rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic        [7:0]  rsp_list_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW + 1 > 9) ? CW + 1 : 9;

   logic [31:0] mem [CAPACITY];

   kind_type           kind_ff;
   logic        [7:0]  pos_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic [31:0]        rdata_ff;
   logic               ok_ff;
   logic [7:0]         found_ff;
   logic signed [31:0] rval_ff;

   logic [EW-1:0] pos_e, cnt_e, idx_e, pos_m1, idx_p1, rd_addr, wr_addr;
   logic [31:0]   wr_data;
   logic          pos_nz, in_range, ins_range;

   assign pos_e  = EW'(pos_ff);
   assign cnt_e  = EW'(count_ff);
   assign idx_e  = EW'(idx_ff);
   assign pos_m1 = pos_e - EW'(1);
   assign idx_p1 = idx_e + EW'(1);
   assign pos_nz = (pos_ff != 8'd0);

   assign in_range  = pos_nz && (pos_e <= cnt_e);
   assign ins_range = pos_nz && (pos_e <= cnt_e + EW'(1)) && (cnt_e < EW'(CAPACITY));

   always_comb begin
      st.kind   = kind_ff;
      st.pos_ok = (kind_ff == KIND_INSERT) ? ins_range : in_range;
      st.match  = (rdata_ff == value_ff);
      case (kind_ff)
         KIND_INSERT: begin
            st.more = (idx_e > pos_m1);
            rd_addr = idx_e - EW'(1);
         end
         KIND_DELETE: begin
            st.more = (idx_p1 < cnt_e);
            rd_addr = idx_p1;
         end
         KIND_LOCATE: begin
            st.more = (idx_e < cnt_e);
            rd_addr = idx_e;
         end
         default: begin
            st.more = 1'b0;
            rd_addr = pos_m1;
         end
      endcase
   end

   assign wr_addr = cmd.wr_value ? pos_m1 : idx_e;
   assign wr_data = cmd.wr_value ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[rd_addr[AW-1:0]];
      end
      if (cmd.wr_shift || cmd.wr_value) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(req_kind);
         pos_ff   <= req_position;
         value_ff <= req_value;
         ok_ff    <= 1'b0;
         found_ff <= 8'd0;
         rval_ff  <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.take_rval) begin
            ok_ff   <= 1'b1;
            rval_ff <= rdata_ff;
         end
         if (cmd.take_found) begin
            found_ff <= idx_p1[7:0];
         end
      end
      if (cmd.idx_init) begin
         case (kind_ff)
            KIND_INSERT: idx_ff <= count_ff;
            KIND_DELETE: idx_ff <= pos_m1[CW-1:0];
            default:     idx_ff <= '0;
         endcase
      end else if (cmd.idx_step) begin
         idx_ff <= (kind_ff == KIND_INSERT) ? idx_ff - CW'(1) : idx_ff + CW'(1);
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_found_position = found_ff;
   assign rsp_read_value     = rval_ff;
   assign rsp_list_count     = cnt_e[7:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_e <= EW'(CAPACITY))
      else $error("entry count above capacity");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> (cnt_e < EW'(CAPACITY)))
      else $error("insert into full list");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> (count_ff != '0))
      else $error("delete from empty list");

endmodule

// File: hw/rtl/positional_array_list.sv
// ---------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed 32-bit values addressed by 1-based position.
//
// Request channel: req_kind, req_position, req_value are taken on a rising
// edge with start high and busy low. Kinds: get, locate, insert, delete.
// Result channel: rsp_strobe is high for one cycle with rsp_ok,
// rsp_found_position, rsp_read_value and rsp_list_count; the receiver must
// take it then, it cannot stall the block. busy stays high until that cycle.
// One memory access per cycle, on a single read and a single write port.
// Locate compares entries in order until a hit or the end of the list;
// insert and delete shift the entries from the position on. Shift and
// scan loops step one entry at a time (read, then write or compare).
// A new item may be accepted in the strobe cycle.
// Reset (synchronous) empties the list; memory contents are not cleared
// since entries beyond the count are never read.
// ---------------------------------------------------------------------------
module positional_array_list
   import pal_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [1:0]  req_kind,
   input  logic        [7:0]  req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic        [7:0]  rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic        [7:0]  rsp_list_count
);

   cmd_type    cmd;
   status_type st;

   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .st         (st),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pal_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_read_value     (rsp_read_value),
      .rsp_list_count     (rsp_list_count)
   );

endmodule
